// ----- hdl/integer_to_ascii_formatter_core_assert.svh -----
// Assertion macros for the integer to ASCII formatter core
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// check a consequence in the same cycle, on clk, quiet during rst
`define ITAF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itaf assertion failed");

// check a consequence in the cycle after the antecedent, on clk, quiet during rst
`define ITAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itaf assertion failed");

`endif

// ----- hdl/itaf_pkg.sv -----
// Shared constants, types and a function of the integer to ASCII formatter
package itaf_pkg;

  localparam int ValueW       = 32;
  localparam int FuncW        = 2;
  localparam int HexW         = 4;
  localparam int CharW        = 7;
  localparam int DigitCnt     = 10;
  localparam int BcdW         = 4 * DigitCnt;
  localparam int LeftW        = 4;
  localparam int DabbleStages = 4;
  localparam int BitsPerStage = ValueW / DabbleStages;

  localparam logic [FuncW-1:0] FuncDec16 = 2'd0;
  localparam logic [FuncW-1:0] FuncDec32 = 2'd1;
  localparam logic [FuncW-1:0] FuncHex   = 2'd2;

  localparam logic [CharW-1:0] AsciiZero   = 7'h30;
  localparam logic [CharW-1:0] AsciiLowerA = 7'h61;
  localparam logic [CharW-1:0] AsciiMinus  = 7'h2d;

  localparam logic [HexW-1:0]  MaxHexNibbles = 4'd8;
  localparam logic [LeftW-1:0] MaxDigits     = 4'd10;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic              neg;
    logic [HexW-1:0]   hex_cnt;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } conv_t;

  function automatic logic [CharW-1:0] digit_to_ascii(input logic [3:0] d);
    logic [CharW-1:0] code;
    if (d < 4'd10) begin
      code = AsciiZero + CharW'(d);
    end else begin
      code = AsciiLowerA + CharW'(d - 4'd10);
    end
    return code;
  endfunction

endpackage

// ----- hdl/itaf_if.sv -----
// Request and character channel interfaces of the formatter
interface itaf_req_if;
  logic                           valid;
  logic                           ready;
  logic [itaf_pkg::FuncW-1:0]     func;
  logic signed [itaf_pkg::ValueW-1:0] value;
  logic [itaf_pkg::HexW-1:0]      hex_digits;

  modport source (output valid, output func, output value, output hex_digits, input ready);
  modport sink   (input valid, input func, input value, input hex_digits, output ready);
endinterface

interface itaf_char_if;
  logic                       valid;
  logic                       ready;
  logic [itaf_pkg::CharW-1:0] char_code;
  logic                       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- hdl/integer_to_ascii_formatter_core.sv -----
// Integer to ASCII formatter: pipelined binary to BCD and character emitter
//
//   channel | dir | payload                   | handshake
//   req     | in  | func, value, hex_digits   | valid/ready
//   chr     | out | char_code, last           | valid/ready
//
// A request passes an input stage, four double-dabble stages of eight bits
// each and a digit count stage, then waits in the emitter.
// The emitter sends one character per cycle while chr takes them, and a
// request gives 1 to 11 characters.
// Requests in mode three or in hex mode with zero hex digits give no characters.
// rst clears all valid bits and the emitter; payload registers keep junk.
// A stall on chr holds the output register and backs up the whole pipeline.
`include "integer_to_ascii_formatter_core_assert.svh"

module integer_to_ascii_formatter_core (
  input  logic        clk,
  input  logic        rst,
  itaf_req_if.sink    req,
  itaf_char_if.source chr
);

  itaf_pkg::conv_t                        s [itaf_pkg::DabbleStages+1];
  itaf_pkg::conv_t                        s0_next;
  itaf_pkg::conv_t                        s_next [1:itaf_pkg::DabbleStages];
  logic [itaf_pkg::DabbleStages:0]        vld;

  logic                                   c_valid;
  logic                                   c_sign;
  logic [itaf_pkg::LeftW-1:0]             c_left;
  logic [itaf_pkg::DigitCnt-1:0][3:0]     c_digits;
  logic                                   c_sign_next;
  logic [itaf_pkg::LeftW-1:0]             c_left_next;

  logic                                   e_busy;
  logic                                   e_sign;
  logic [itaf_pkg::LeftW-1:0]             e_left;
  logic [itaf_pkg::DigitCnt-1:0][3:0]     e_digits;
  logic [itaf_pkg::LeftW-1:0]             e_idx;
  logic                                   e_fin;

  logic                                   o_valid;
  logic [itaf_pkg::CharW-1:0]             o_char;
  logic                                   o_last;

  logic                                   out_free;
  logic                                   emit;
  logic                                   emit_load;
  logic                                   en;

  function automatic logic [itaf_pkg::BcdW+itaf_pkg::ValueW-1:0] dabble_step(
    input logic [itaf_pkg::BcdW+itaf_pkg::ValueW-1:0] x
  );
    logic [itaf_pkg::BcdW+itaf_pkg::ValueW-1:0] y;
    y = x;
    for (int i = 0; i < itaf_pkg::DigitCnt; i++) begin
      if (y[itaf_pkg::ValueW + 4*i +: 4] >= 4'd5) begin
        y[itaf_pkg::ValueW + 4*i +: 4] = y[itaf_pkg::ValueW + 4*i +: 4] + 4'd3;
      end
    end
    return y << 1;
  endfunction

  assign out_free  = !o_valid || chr.ready;
  assign emit      = out_free && e_busy;
  assign e_fin     = e_sign ? (e_left == '0) : (e_left == 4'd1);
  assign e_idx     = e_left - 4'd1;
  assign emit_load = c_valid && (!e_busy || (emit && e_fin));
  assign en        = !c_valid || emit_load;

  assign req.ready     = en;
  assign chr.valid     = o_valid;
  assign chr.char_code = o_char;
  assign chr.last      = o_last;

  // input stage: sign, magnitude and hex count
  always_comb begin
    logic [15:0] v16;
    v16 = req.value[15:0];
    s0_next         = '0;
    s0_next.func    = req.func;
    s0_next.hex_cnt = (req.hex_digits > itaf_pkg::MaxHexNibbles) ?
                      itaf_pkg::MaxHexNibbles : req.hex_digits;
    case (req.func)
      itaf_pkg::FuncDec16: begin
        s0_next.neg = v16[15];
        s0_next.bin = {16'b0, (v16[15] ? 16'(16'd0 - v16) : v16)};
      end
      itaf_pkg::FuncDec32: begin
        s0_next.neg = req.value[31];
        s0_next.bin = req.value[31] ? 32'(32'd0 - req.value) : req.value;
      end
      itaf_pkg::FuncHex: begin
        s0_next.bcd = {8'b0, req.value};
      end
      default: begin
        s0_next.bin = '0;
      end
    endcase
  end

  // dabble stages
  always_comb begin
    logic [itaf_pkg::BcdW+itaf_pkg::ValueW-1:0] x;
    for (int k = 1; k <= itaf_pkg::DabbleStages; k++) begin
      s_next[k] = s[k-1];
      x = {s[k-1].bcd, s[k-1].bin};
      for (int j = 0; j < itaf_pkg::BitsPerStage; j++) begin
        x = dabble_step(x);
      end
      if (s[k-1].func != itaf_pkg::FuncHex) begin
        s_next[k].bcd = x[itaf_pkg::ValueW +: itaf_pkg::BcdW];
        s_next[k].bin = x[itaf_pkg::ValueW-1:0];
      end
    end
  end

  // digit count stage
  always_comb begin
    logic [itaf_pkg::LeftW-1:0] cnt;
    cnt = 4'd1;
    for (int i = 1; i < itaf_pkg::DigitCnt; i++) begin
      if (s[itaf_pkg::DabbleStages].bcd[4*i +: 4] != 4'd0) begin
        cnt = itaf_pkg::LeftW'(i + 1);
      end
    end
    case (s[itaf_pkg::DabbleStages].func)
      itaf_pkg::FuncDec16, itaf_pkg::FuncDec32: begin
        c_sign_next = s[itaf_pkg::DabbleStages].neg;
        c_left_next = cnt;
      end
      itaf_pkg::FuncHex: begin
        c_sign_next = 1'b0;
        c_left_next = s[itaf_pkg::DabbleStages].hex_cnt;
      end
      default: begin
        c_sign_next = 1'b0;
        c_left_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      c_valid <= 1'b0;
    end else if (en) begin
      vld     <= {vld[itaf_pkg::DabbleStages-1:0], req.valid};
      c_valid <= vld[itaf_pkg::DabbleStages];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s[0] <= s0_next;
      for (int k = 1; k <= itaf_pkg::DabbleStages; k++) begin
        s[k] <= s_next[k];
      end
      c_sign   <= c_sign_next;
      c_left   <= c_left_next;
      c_digits <= s[itaf_pkg::DabbleStages].bcd;
    end
  end

  // emitter and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      e_busy  <= 1'b0;
      e_sign  <= 1'b0;
      e_left  <= '0;
      o_valid <= 1'b0;
    end else begin
      if (emit) begin
        o_valid <= 1'b1;
      end else if (chr.ready) begin
        o_valid <= 1'b0;
      end
      if (emit_load) begin
        e_busy <= c_sign || (c_left != '0);
        e_sign <= c_sign;
        e_left <= c_left;
      end else if (emit) begin
        if (e_sign) begin
          e_sign <= 1'b0;
        end else begin
          e_left <= e_idx;
        end
        if (e_fin) begin
          e_busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      e_digits <= c_digits;
    end
    if (emit) begin
      o_char <= e_sign ? itaf_pkg::AsciiMinus : itaf_pkg::digit_to_ascii(e_digits[e_idx]);
      o_last <= e_fin;
    end
  end

  `ITAF_ASSERT_NOW(a_busy_has_work, e_busy, e_sign || (e_left != '0))
  `ITAF_ASSERT_NOW(a_left_in_range, e_busy, e_left <= itaf_pkg::MaxDigits)
  `ITAF_ASSERT_NOW(a_minus_not_last, o_valid && (o_char == itaf_pkg::AsciiMinus), !o_last)
  `ITAF_ASSERT_NEXT(a_idle_after_last, emit && e_fin && !emit_load, !e_busy)

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the integer to ASCII formatter: directed table, then random requests
`timescale 1ns / 100ps

module tb;

  localparam logic [itaf_pkg::FuncW-1:0] FuncUnused = 2'd3;

  localparam int HalfPeriod     = 5;
  localparam int ResetCycles    = 4;
  localparam int NumDirected    = 24;
  localparam int RandomRequests = 232;
  localparam int HoldOffCycles  = 300;
  localparam int DrainCycles    = 24;
  localparam int CycleLimit     = 200000;

  typedef struct packed {
    logic [itaf_pkg::CharW-1:0] char_code;
    logic                       last;
  } glyph_t;

  typedef struct {
    logic [itaf_pkg::FuncW-1:0]  func;
    logic [itaf_pkg::ValueW-1:0] value;
    logic [itaf_pkg::HexW-1:0]   hex_digits;
    bit                          typed;
    string                       text;
  } row_t;

  typedef enum int {SinkOpen, SinkCoin, SinkEveryThird, SinkMostly} sink_mode_t;

  logic clk;
  logic rst;

  itaf_req_if  req_ch ();
  itaf_char_if chr_ch ();

  integer_to_ascii_formatter_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .chr (chr_ch)
  );

  row_t directed_rows [NumDirected] = '{
    '{itaf_pkg::FuncDec16, 32'h0000_0000, 4'd0,  1'b1, "0"},
    '{itaf_pkg::FuncDec16, 32'h0000_7fff, 4'd0,  1'b1, "32767"},
    '{itaf_pkg::FuncDec16, 32'h0000_8000, 4'd0,  1'b1, "-32768"},
    '{itaf_pkg::FuncDec16, 32'hffff_ffff, 4'd15, 1'b1, "-1"},
    '{itaf_pkg::FuncDec16, 32'h1234_5678, 4'd9,  1'b0, ""},
    '{itaf_pkg::FuncDec16, 32'hffff_0001, 4'd0,  1'b0, ""},
    '{itaf_pkg::FuncDec32, 32'h0000_0000, 4'd0,  1'b1, "0"},
    '{itaf_pkg::FuncDec32, 32'h7fff_ffff, 4'd0,  1'b1, "2147483647"},
    '{itaf_pkg::FuncDec32, 32'h8000_0000, 4'd0,  1'b1, "-2147483648"},
    '{itaf_pkg::FuncDec32, 32'hffff_ffff, 4'd0,  1'b1, "-1"},
    '{itaf_pkg::FuncDec32, 32'h8000_0001, 4'd7,  1'b0, ""},
    '{itaf_pkg::FuncDec32, 32'd1000000000, 4'd0, 1'b0, ""},
    '{itaf_pkg::FuncDec32, 32'd9,         4'd0,  1'b1, "9"},
    '{itaf_pkg::FuncHex,   32'hdead_beef, 4'd8,  1'b1, "deadbeef"},
    '{itaf_pkg::FuncHex,   32'h0000_000a, 4'd8,  1'b1, "0000000a"},
    '{itaf_pkg::FuncHex,   32'h1234_5678, 4'd1,  1'b1, "8"},
    '{itaf_pkg::FuncHex,   32'hffff_ffff, 4'd15, 1'b1, "ffffffff"},
    '{itaf_pkg::FuncHex,   32'h89ab_cdef, 4'd9,  1'b0, ""},
    '{itaf_pkg::FuncHex,   32'h1234_5678, 4'd0,  1'b1, ""},
    '{itaf_pkg::FuncHex,   32'h0000_0000, 4'd4,  1'b1, "0000"},
    '{itaf_pkg::FuncHex,   32'habcd_ef01, 4'd3,  1'b0, ""},
    '{itaf_pkg::FuncHex,   32'h0123_4567, 4'd2,  1'b0, ""},
    '{FuncUnused,          32'hffff_ffff, 4'd15, 1'b1, ""},
    '{FuncUnused,          32'h0000_0000, 4'd0,  1'b1, ""}
  };

  glyph_t expected_glyphs [$];

  int  mismatches;
  int  requests_sent;
  int  silent_requests;
  int  glyphs_checked;
  int  cycle_count;
  int  burst_left;
  bit  random_phase;
  bit  hold_off;

  always begin
    clk = 1'b0;
    #HalfPeriod;
    clk = 1'b1;
    #HalfPeriod;
  end

  function automatic string render_number(input logic [itaf_pkg::FuncW-1:0] func,
                                          input logic [itaf_pkg::ValueW-1:0] value,
                                          input logic [itaf_pkg::HexW-1:0] hex_digits);
    logic [itaf_pkg::ValueW-1:0] mag;
    logic                        neg;
    int                          nibbles;
    string                       text;
    text = "";
    neg  = 1'b0;
    mag  = '0;
    case (func)
      itaf_pkg::FuncDec16: begin
        neg = value[15];
        mag = neg ? 32'h0001_0000 - {16'h0, value[15:0]} : {16'h0, value[15:0]};
      end
      itaf_pkg::FuncDec32: begin
        neg = value[31];
        mag = neg ? -value : value;
      end
      default: ;
    endcase
    if (func == itaf_pkg::FuncHex) begin
      nibbles = (hex_digits > itaf_pkg::MaxHexNibbles) ?
                int'(itaf_pkg::MaxHexNibbles) : int'(hex_digits);
      text = $sformatf("%08x", value);
      text = (nibbles == 0) ? "" : text.substr(8 - nibbles, 7);
    end else if (func != FuncUnused) begin
      text = $sformatf("%0d", mag);
      if (neg) begin
        text = {"-", text};
      end
    end
    return text;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic offer(input logic [itaf_pkg::FuncW-1:0] func,
                       input logic [itaf_pkg::ValueW-1:0] value,
                       input logic [itaf_pkg::HexW-1:0] hex_digits, input bit typed,
                       input string typed_text, output int produced);
    string  text;
    glyph_t g;
    byte    c;
    req_ch.valid      <= 1'b1;
    req_ch.func       <= func;
    req_ch.value      <= value;
    req_ch.hex_digits <= hex_digits;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    text = typed ? typed_text : render_number(func, value, hex_digits);
    for (int i = 0; i < text.len(); i++) begin
      c           = text[i];
      g.char_code = c[itaf_pkg::CharW-1:0];
      g.last      = (i == text.len() - 1);
      expected_glyphs.push_back(g);
    end
    produced = text.len();
    requests_sent++;
    if (produced == 0) begin
      silent_requests++;
    end
    burst_left--;
    if (burst_left <= 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 12);
    end
  endtask

  initial begin : stimulus
    int                          produced;
    int                          random_hits;
    int                          r;
    logic [itaf_pkg::FuncW-1:0]  f;
    logic [itaf_pkg::ValueW-1:0] v;
    logic [itaf_pkg::HexW-1:0]   h;
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= itaf_pkg::FuncDec16;
    req_ch.value      <= '0;
    req_ch.hex_digits <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    burst_left = $urandom_range(1, 12);

    for (int i = 0; i < NumDirected; i++) begin
      offer(directed_rows[i].func, directed_rows[i].value, directed_rows[i].hex_digits,
            directed_rows[i].typed, directed_rows[i].text, produced);
    end

    random_phase = 1'b1;
    random_hits  = 0;
    while (random_hits < RandomRequests) begin
      r = $urandom_range(0, 19);
      f = (r < 6) ? itaf_pkg::FuncDec16 : (r < 12) ? itaf_pkg::FuncDec32 :
          (r < 19) ? itaf_pkg::FuncHex : FuncUnused;
      case ($urandom_range(0, 7))
        1: begin
          v = 32'($urandom_range(0, 40));
          if ($urandom_range(0, 1) == 1) v = -v;
        end
        2: begin
          case ($urandom_range(0, 5))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'h0000_8000;
            3: v = 32'h0000_7fff;
            4: v = 32'hffff_ffff;
            default: v = '0;
          endcase
        end
        3: begin
          v = 32'd1;
          repeat ($urandom_range(0, 9)) v = v * 32'd10;
          v = v + 32'($urandom_range(0, 2)) - 32'd1;
          if ($urandom_range(0, 1) == 1) v = -v;
        end
        default: v = $urandom;
      endcase
      h = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 8));
      offer(f, v, h, 1'b0, "", produced);
      if (produced > 0) begin
        random_hits++;
      end
    end

    req_ch.valid <= 1'b0;
    while (expected_glyphs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d requests (%0d from the table, %0d producing no text), %0d chars",
             requests_sent, NumDirected, silent_requests, glyphs_checked);
    $display("receiver held off once for %0d cycles; %0d mismatches",
             HoldOffCycles, mismatches);
    if (mismatches == 0) begin
      $display("integer_to_ascii_formatter_core verification clean");
    end else begin
      $display("integer_to_ascii_formatter_core verification failed");
    end
    $finish;
  end

  initial begin : char_sink
    int         phase_left;
    sink_mode_t sink_mode;
    logic       take;
    phase_left = 0;
    sink_mode  = SinkOpen;
    chr_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        sink_mode  = sink_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 80);
      end
      phase_left--;
      case (sink_mode)
        SinkOpen:       take = 1'b1;
        SinkCoin:       take = ($urandom_range(0, 1) == 1);
        SinkEveryThird: take = ((phase_left % 3) == 0);
        default:        take = ($urandom_range(0, 7) != 0);
      endcase
      chr_ch.ready <= take && !hold_off;
    end
  end

  initial begin : long_hold_off
    wait (random_phase);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin : char_check
    glyph_t want;
    if (!rst && chr_ch.valid && chr_ch.ready) begin
      if (expected_glyphs.size() == 0) begin
        note_mismatch("unrequested char", int'(chr_ch.char_code), 0);
      end else begin
        want = expected_glyphs.pop_front();
        glyphs_checked++;
        if (chr_ch.char_code !== want.char_code) begin
          note_mismatch("char_code", int'(chr_ch.char_code), int'(want.char_code));
        end
        if (chr_ch.last !== want.last) begin
          note_mismatch("last", int'(chr_ch.last), int'(want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("integer_to_ascii_formatter_core verification failed");
      $finish;
    end
  end

endmodule
